@@ design/sfs_pkg.sv @@
// ----------------------------------------------------------------------------
// sfs_pkg
// Shared types and constants for the sprite frame sequencer.
// ----------------------------------------------------------------------------
package sfs_pkg;

  // field widths
  localparam int FRAME_W    = 8;
  localparam int POS_W      = 9;
  localparam int LEN_W      = 10;
  localparam int PIX_W      = 18;
  localparam int PERIOD_W   = 24;
  localparam int COLS_W     = 9;
  localparam int DIM_W      = 11;
  localparam int PROD_W     = FRAME_W + DIM_W;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;
  localparam int OP_W       = 3;

  localparam int MAX_FRAMES = 256;
  localparam logic [PIX_W-1:0] PIX_MAX = '1;

  // one quotient bit per step of the column divider
  localparam int DIV_STEPS = FRAME_W;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  localparam logic [PERIOD_W-1:0] PERIOD_RST = 24'd16667;

  // operation codes
  localparam logic [OP_W-1:0] OP_TICK   = 3'd0;
  localparam logic [OP_W-1:0] OP_START  = 3'd1;
  localparam logic [OP_W-1:0] OP_STOP   = 3'd2;
  localparam logic [OP_W-1:0] OP_PAUSE  = 3'd3;
  localparam logic [OP_W-1:0] OP_RESUME = 3'd4;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SHEET_COLUMNS = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_FIRST_FRAME   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_LAST_FRAME    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_PING_PONG     = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_LOOP_ENABLE   = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_PERIOD  = 3'd7;

  // controller to datapath
  typedef struct packed {
    logic capture;   // latch the incoming item
    logic exec;      // apply command, accumulate time
    logic adv;       // period compare and position step
    logic frame;     // frame lookup, divider init
    logic div_step;  // one restoring divide step
    logic mul;       // pixel products
    logic load_out;  // fill the output register
  } sfs_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic out_free;
  } sfs_status_t;

endpackage

@@ design/sfs_ctrl.sv @@
// ----------------------------------------------------------------------------
// sfs_ctrl
// Sequencing state machine: walks each item through update, frame lookup,
// column divide, pixel multiply and output load.
// ----------------------------------------------------------------------------
module sfs_ctrl import sfs_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  sfs_status_t status_i,
  output sfs_cmd_t    cmd_o
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_EXEC  = 3'd1;
  localparam logic [2:0] S_ADV   = 3'd2;
  localparam logic [2:0] S_FRAME = 3'd3;
  localparam logic [2:0] S_DIV   = 3'd4;
  localparam logic [2:0] S_MUL   = 3'd5;
  localparam logic [2:0] S_DONE  = 3'd6;

  logic [2:0]           state_q, state_d;
  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd_o.exec = 1'b1;
        state_d    = S_ADV;
      end
      S_ADV: begin
        cmd_o.adv = 1'b1;
        state_d   = S_FRAME;
      end
      S_FRAME: begin
        cmd_o.frame = 1'b1;
        cnt_d       = '0;
        state_d     = S_DIV;
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        cnt_d          = cnt_q + 1'b1;
        if (cnt_q == DIV_CNT_W'(DIV_STEPS - 1)) begin
          state_d = S_MUL;
        end
      end
      S_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = S_DONE;
      end
      S_DONE: begin
        // wait here only while the previous result is still unread
        if (status_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule

@@ design/sfs_datapath.sv @@
// ----------------------------------------------------------------------------
// sfs_datapath
// Config registers, play state, frame lookup, shift-subtract column divider,
// pixel multipliers and the output register.
// ----------------------------------------------------------------------------
module sfs_datapath import sfs_pkg::*; #(
  parameter int TIME_BITS = 24
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_valid_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic [OP_W-1:0]       operation_i,
  input  logic [TIME_BITS-1:0]  elapsed_time_i,
  input  sfs_cmd_t              cmd_i,
  output sfs_status_t           status_o,
  input  logic                  out_ready_i,
  output logic                  out_valid_o,
  output logic [FRAME_W-1:0]    frame_number_o,
  output logic [PIX_W-1:0]      frame_x_o,
  output logic [PIX_W-1:0]      frame_y_o,
  output logic                  playing_o,
  output logic [POS_W-1:0]      sequence_index_o
);

  localparam int AW = TIME_BITS + 1;
  localparam int CW = (AW > PERIOD_W) ? AW : PERIOD_W;

  // configuration
  logic [COLS_W-1:0]   sheet_columns_q;
  logic [DIM_W-1:0]    frame_width_q, frame_height_q;
  logic [FRAME_W-1:0]  first_frame_q, last_frame_q;
  logic                ping_pong_q, loop_enable_q;
  logic [PERIOD_W-1:0] frame_period_q;

  // play state
  logic [AW-1:0]    acc_q, acc_d;
  logic [POS_W-1:0] pos_q, pos_d;
  logic             running_q, running_d;

  // captured item
  logic [OP_W-1:0]      op_q;
  logic [TIME_BITS-1:0] el_q;

  // frame / divide / multiply
  logic [FRAME_W-1:0] frame_q, frame_d;
  logic [FRAME_W-1:0] quo_q, rem_q;
  logic [PROD_W-1:0]  x_prod_q, y_prod_q;

  // output register
  logic               out_valid_q;
  logic [FRAME_W-1:0] out_frame_q;
  logic [PIX_W-1:0]   out_x_q, out_y_q;
  logic               out_playing_q;
  logic [POS_W-1:0]   out_pos_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sheet_columns_q <= COLS_W'(1);
      frame_width_q   <= DIM_W'(1);
      frame_height_q  <= DIM_W'(1);
      first_frame_q   <= '0;
      last_frame_q    <= '0;
      ping_pong_q     <= 1'b0;
      loop_enable_q   <= 1'b0;
      frame_period_q  <= PERIOD_RST;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_SHEET_COLUMNS: sheet_columns_q <= cfg_data_i[COLS_W-1:0];
        CFG_FRAME_WIDTH:   frame_width_q   <= cfg_data_i[DIM_W-1:0];
        CFG_FRAME_HEIGHT:  frame_height_q  <= cfg_data_i[DIM_W-1:0];
        CFG_FIRST_FRAME:   first_frame_q   <= cfg_data_i[FRAME_W-1:0];
        CFG_LAST_FRAME:    last_frame_q    <= cfg_data_i[FRAME_W-1:0];
        CFG_PING_PONG:     ping_pong_q     <= cfg_data_i[0];
        CFG_LOOP_ENABLE:   loop_enable_q   <= cfg_data_i[0];
        CFG_FRAME_PERIOD:  frame_period_q  <= cfg_data_i[PERIOD_W-1:0];
        default: ;
      endcase
    end
  end

  // sequence geometry
  logic [FRAME_W-1:0] span;
  logic [LEN_W-1:0]   seq_len;
  logic               reverse;

  always_comb begin
    reverse = (first_frame_q > last_frame_q);
    span    = reverse ? (first_frame_q - last_frame_q) : (last_frame_q - first_frame_q);
    if (span == '0) begin
      seq_len = LEN_W'(1);
    end else if (!ping_pong_q) begin
      seq_len = LEN_W'(span) + LEN_W'(1);
    end else begin
      seq_len = {1'b0, span, 1'b0} + LEN_W'(!loop_enable_q);
    end
  end

  // state update: command/accumulate, then compare and advance
  logic [AW:0]      acc_sum;
  logic [AW-1:0]    acc_sat;
  logic             acc_ge;
  logic [CW-1:0]    acc_sub;
  logic [LEN_W-1:0] pos_inc;
  logic [LEN_W-1:0] last_idx;

  always_comb begin
    acc_sum  = {1'b0, acc_q} + (AW+1)'(el_q);
    acc_sat  = acc_sum[AW] ? '1 : acc_sum[AW-1:0];
    acc_ge   = (CW'(acc_q) >= CW'(frame_period_q));
    acc_sub  = CW'(acc_q) - CW'(frame_period_q);
    pos_inc  = LEN_W'(pos_q) + LEN_W'(1);
    last_idx = seq_len - LEN_W'(1);

    acc_d     = acc_q;
    pos_d     = pos_q;
    running_d = running_q;

    if (cmd_i.exec) begin
      case (op_q)
        OP_TICK: begin
          if (running_q) begin
            acc_d = acc_sat;
          end
        end
        OP_START: begin
          running_d = 1'b1;
          pos_d     = '0;
        end
        OP_STOP: begin
          running_d = 1'b0;
          pos_d     = '0;
        end
        OP_PAUSE:  running_d = 1'b0;
        OP_RESUME: running_d = 1'b1;
        default: ;
      endcase
    end

    if (cmd_i.adv && (op_q == OP_TICK) && running_q && acc_ge) begin
      acc_d = acc_sub[AW-1:0];
      if (pos_inc >= seq_len) begin
        if (loop_enable_q) begin
          pos_d = '0;
        end else begin
          pos_d     = last_idx[POS_W-1:0];
          running_d = 1'b0;
        end
      end else begin
        pos_d = pos_inc[POS_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q     <= '0;
      pos_q     <= '0;
      running_q <= 1'b0;
    end else begin
      acc_q     <= acc_d;
      pos_q     <= pos_d;
      running_q <= running_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q <= operation_i;
      el_q <= elapsed_time_i;
    end
  end

  // frame lookup; a position past the end shows the last entry
  logic [LEN_W-1:0] p_eff, k_step, f_wide;

  always_comb begin
    p_eff  = (LEN_W'(pos_q) >= seq_len) ? last_idx : LEN_W'(pos_q);
    k_step = (p_eff <= LEN_W'(span)) ? p_eff : ({1'b0, span, 1'b0} - p_eff);
    f_wide = reverse ? (LEN_W'(first_frame_q) - k_step) : (LEN_W'(first_frame_q) + k_step);
    if (int'(f_wide) >= MAX_FRAMES) begin
      frame_d = FRAME_W'(MAX_FRAMES - 1);
    end else begin
      frame_d = f_wide[FRAME_W-1:0];
    end
  end

  // restoring divide by column count, zero columns acts as one
  logic [COLS_W-1:0] cols_eff;
  logic [COLS_W-1:0] shifted;
  logic              q_bit;
  logic [COLS_W-1:0] rem_next;

  always_comb begin
    cols_eff = (sheet_columns_q == '0) ? COLS_W'(1) : sheet_columns_q;
    shifted  = {rem_q, quo_q[FRAME_W-1]};
    q_bit    = (shifted >= cols_eff);
    rem_next = q_bit ? (shifted - cols_eff) : shifted;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.frame) begin
      frame_q <= frame_d;
      quo_q   <= frame_d;
      rem_q   <= '0;
    end else if (cmd_i.div_step) begin
      quo_q <= {quo_q[FRAME_W-2:0], q_bit};
      rem_q <= rem_next[FRAME_W-1:0];
    end
    if (cmd_i.mul) begin
      x_prod_q <= PROD_W'(rem_q) * PROD_W'(frame_width_q);
      y_prod_q <= PROD_W'(quo_q) * PROD_W'(frame_height_q);
    end
  end

  // output register
  assign status_o.out_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_frame_q   <= frame_q;
      out_x_q       <= (x_prod_q > PROD_W'(PIX_MAX)) ? PIX_MAX : x_prod_q[PIX_W-1:0];
      out_y_q       <= (y_prod_q > PROD_W'(PIX_MAX)) ? PIX_MAX : y_prod_q[PIX_W-1:0];
      out_playing_q <= running_q;
      out_pos_q     <= pos_q;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign frame_number_o   = out_frame_q;
  assign frame_x_o        = out_x_q;
  assign frame_y_o        = out_y_q;
  assign playing_o        = out_playing_q;
  assign sequence_index_o = out_pos_q;

endmodule

@@ design/sprite_frame_sequencer.sv @@
// ----------------------------------------------------------------------------
// sprite_frame_sequencer
// Sprite sheet animation sequencer: time ticks and play commands in, shown
// frame and its pixel position in the sheet out, one result per item.
// ----------------------------------------------------------------------------
//  channel  direction  handshake                 payload
//  in       input      in_valid_i / in_ready_o   operation_i, elapsed_time_i
//  out      output     out_valid_o / out_ready_i frame_number_o, frame_x_o,
//                                                frame_y_o, playing_o,
//                                                sequence_index_o
//  cfg      input      cfg_valid_i / cfg_ready_o cfg_index_i, cfg_data_i
//
//  An item passes capture, update, advance, frame lookup, the 8-step column
//  divider (one quotient bit per cycle), pixel multiply and output load.
//  Items are handled one at a time; in_ready_o rises again once the result
//  is in the output register, so the next item can enter while it waits.
//  If the previous result is still unread the controller holds the new one.
//  Reset is asynchronous and clears play state and config to defaults.
// ----------------------------------------------------------------------------
module sprite_frame_sequencer import sfs_pkg::*; #(
  parameter int TIME_BITS = 24
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [OP_W-1:0]       operation_i,
  input  logic [TIME_BITS-1:0]  elapsed_time_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [FRAME_W-1:0]    frame_number_o,
  output logic [PIX_W-1:0]      frame_x_o,
  output logic [PIX_W-1:0]      frame_y_o,
  output logic                  playing_o,
  output logic [POS_W-1:0]      sequence_index_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  sfs_cmd_t    cmd;
  sfs_status_t status;

  assign cfg_ready_o = 1'b1;

  sfs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  sfs_datapath #(
    .TIME_BITS (TIME_BITS)
  ) u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .operation_i      (operation_i),
    .elapsed_time_i   (elapsed_time_i),
    .cmd_i            (cmd),
    .status_o         (status),
    .out_ready_i      (out_ready_i),
    .out_valid_o      (out_valid_o),
    .frame_number_o   (frame_number_o),
    .frame_x_o        (frame_x_o),
    .frame_y_o        (frame_y_o),
    .playing_o        (playing_o),
    .sequence_index_o (sequence_index_o)
  );

endmodule

@@ bench/sprite_frame_sequencer_test.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sprite_frame_sequencer_test
// Self-checking bench for the sprite frame sequencer. A shadow of the play
// state predicts each shown frame. Directed items cover edge configs and
// commands. Random phases follow, with idle and stall patterns that change
// with each group of three phases.
// ----------------------------------------------------------------------------
module sprite_frame_sequencer_test import sfs_pkg::*;;

  localparam int TB_TIME_BITS = 24;
  localparam int unsigned ACC_FULL = (1 << (TB_TIME_BITS + 1)) - 1;
  localparam int DRAIN_CYCLES = 16;
  localparam logic [OP_W-1:0] OP_RSVD_LO = 3'd5;
  localparam logic [OP_W-1:0] OP_RSVD_HI = 3'd7;

  typedef struct packed {
    logic [FRAME_W-1:0] frame;
    logic [PIX_W-1:0]   x;
    logic [PIX_W-1:0]   y;
    logic               playing;
    logic [POS_W-1:0]   index;
  } sprite_view_t;

  // shadow of the register file and play state, plus the frames still owed
  class playback_shadow;
    logic [COLS_W-1:0]       cols;
    logic [DIM_W-1:0]        fw, fh;
    logic [FRAME_W-1:0]      first, last;
    logic                    ping, loop_en;
    logic [PERIOD_W-1:0]     period;
    logic [TB_TIME_BITS:0]   acc;
    logic [POS_W-1:0]        pos;
    logic                    run;
    sprite_view_t            shown_q[$];
    int                      errors;

    function new();
      cols = 1;
      fw = 1;
      fh = 1;
      first = '0;
      last = '0;
      ping = 1'b0;
      loop_en = 1'b0;
      period = PERIOD_RST;
      acc = '0;
      pos = '0;
      run = 1'b0;
      errors = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_SHEET_COLUMNS: cols = data[COLS_W-1:0];
        CFG_FRAME_WIDTH:   fw = data[DIM_W-1:0];
        CFG_FRAME_HEIGHT:  fh = data[DIM_W-1:0];
        CFG_FIRST_FRAME:   first = data[FRAME_W-1:0];
        CFG_LAST_FRAME:    last = data[FRAME_W-1:0];
        CFG_PING_PONG:     ping = data[0];
        CFG_LOOP_ENABLE:   loop_en = data[0];
        CFG_FRAME_PERIOD:  period = data[PERIOD_W-1:0];
        default: ;
      endcase
    endfunction

    function void take_item(logic [OP_W-1:0] op, logic [TB_TIME_BITS-1:0] el);
      int unsigned d, len, p, k, f, c, px, py, sum;
      sprite_view_t want;
      d = (first > last) ? first - last : last - first;
      if (d == 0) len = 1;
      else if (!ping) len = d + 1;
      else len = loop_en ? 2 * d : 2 * d + 1;
      case (op)
        OP_TICK: if (run) begin
          sum = acc + el;
          acc = (sum > ACC_FULL) ? ACC_FULL : sum;
          if (acc >= period) begin
            acc = acc - period;
            if (pos + 1 >= len) begin
              if (loop_en) begin
                pos = '0;
              end else begin
                pos = len - 1;
                run = 1'b0;
              end
            end else begin
              pos = pos + 1'b1;
            end
          end
        end
        OP_START: begin
          run = 1'b1;
          pos = '0;
        end
        OP_STOP: begin
          run = 1'b0;
          pos = '0;
        end
        OP_PAUSE:  run = 1'b0;
        OP_RESUME: run = 1'b1;
        default: ;
      endcase
      // a position left beyond a shortened sequence shows the last entry
      p = (pos >= len) ? len - 1 : pos;
      k = (p <= d) ? p : 2 * d - p;
      f = (first > last) ? first - k : first + k;
      if (f >= MAX_FRAMES) f = MAX_FRAMES - 1;
      c = (cols == 0) ? 1 : cols;
      px = (f % c) * fw;
      py = (f / c) * fh;
      if (px > PIX_MAX) px = PIX_MAX;
      if (py > PIX_MAX) py = PIX_MAX;
      want.frame = f;
      want.x = px;
      want.y = py;
      want.playing = run;
      want.index = pos;
      shown_q = {shown_q, want};
    endfunction

    function void check_shown(sprite_view_t got);
      sprite_view_t want;
      if (shown_q.size() == 0) begin
        $error("unexpected result: frame_number %0d sequence_index %0d", got.frame,
               got.index);
        errors++;
        return;
      end
      want = shown_q.pop_front();
      if (got.frame !== want.frame) begin
        $error("frame_number expected %0d got %0d", want.frame, got.frame);
        errors++;
      end
      if (got.x !== want.x) begin
        $error("frame_x expected %0d got %0d", want.x, got.x);
        errors++;
      end
      if (got.y !== want.y) begin
        $error("frame_y expected %0d got %0d", want.y, got.y);
        errors++;
      end
      if (got.playing !== want.playing) begin
        $error("playing expected %0d got %0d", want.playing, got.playing);
        errors++;
      end
      if (got.index !== want.index) begin
        $error("sequence_index expected %0d got %0d", want.index, got.index);
        errors++;
      end
    endfunction

    function int pending();
      return shown_q.size();
    endfunction
  endclass

  logic                    clk_i = 1'b0;
  logic                    rst_ni = 1'b0;
  logic                    in_valid_i = 1'b0;
  logic                    in_ready_o;
  logic [OP_W-1:0]         operation_i = OP_TICK;
  logic [TB_TIME_BITS-1:0] elapsed_time_i = '0;
  logic                    out_valid_o;
  logic                    out_ready_i = 1'b0;
  logic [FRAME_W-1:0]      frame_number_o;
  logic [PIX_W-1:0]        frame_x_o;
  logic [PIX_W-1:0]        frame_y_o;
  logic                    playing_o;
  logic [POS_W-1:0]        sequence_index_o;
  logic                    cfg_valid_i = 1'b0;
  logic                    cfg_ready_o;
  logic [CFG_IDX_W-1:0]    cfg_index_i = CFG_SHEET_COLUMNS;
  logic [CFG_DATA_W-1:0]   cfg_data_i = '0;

  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  playback_shadow shadow = new();

  sprite_frame_sequencer #(
    .TIME_BITS(TB_TIME_BITS)
  ) dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .operation_i     (operation_i),
    .elapsed_time_i  (elapsed_time_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .frame_number_o  (frame_number_o),
    .frame_x_o       (frame_x_o),
    .frame_y_o       (frame_y_o),
    .playing_o       (playing_o),
    .sequence_index_o(sequence_index_o),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i)
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  always @(negedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      shadow.check_shown({frame_number_o, frame_x_o, frame_y_o, playing_o,
                          sequence_index_o});
    end
  end

  // all driving tasks start and end on a falling edge
  task automatic send_item(input logic [OP_W-1:0] op, input logic [TB_TIME_BITS-1:0] el);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    operation_i <= op;
    elapsed_time_i <= el;
    do @(posedge clk_i); while (!in_ready_o);
    shadow.take_item(op, el);
    @(negedge clk_i);
  endtask

  // hold off the sender until every owed result is out, then let the core settle
  task automatic drain();
    in_valid_i <= 1'b0;
    do @(negedge clk_i); while (shadow.pending() != 0);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    shadow.set_reg(idx, data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
    @(negedge clk_i);
  endtask

  // sometimes set the unused upper bits of a narrow register
  function automatic logic [CFG_DATA_W-1:0] with_noise(int unsigned v, int w);
    if ($urandom_range(3) == 0) return CFG_DATA_W'(($urandom << w) | v);
    return CFG_DATA_W'(v);
  endfunction

  task automatic shuffle_regs();
    logic [FRAME_W-1:0] a, b;
    logic [PERIOD_W-1:0] per;
    case ($urandom_range(4))
      0, 1: write_reg(CFG_SHEET_COLUMNS, with_noise($urandom_range(1, 16), COLS_W));
      2, 3: write_reg(CFG_SHEET_COLUMNS, with_noise($urandom_range(1, 256), COLS_W));
      default: write_reg(CFG_SHEET_COLUMNS, with_noise($urandom_range(0, 511), COLS_W));
    endcase
    write_reg(CFG_FRAME_WIDTH, with_noise(($urandom_range(2) == 0) ?
              $urandom_range(0, 2047) : $urandom_range(1, 64), DIM_W));
    write_reg(CFG_FRAME_HEIGHT, with_noise(($urandom_range(2) == 0) ?
              $urandom_range(0, 2047) : $urandom_range(1, 64), DIM_W));
    a = $urandom;
    case ($urandom_range(3))
      0: b = a;
      1, 2: b = a + $urandom_range(0, 12) - 6;
      default: b = $urandom;
    endcase
    write_reg(CFG_FIRST_FRAME, with_noise(a, FRAME_W));
    write_reg(CFG_LAST_FRAME, with_noise(b, FRAME_W));
    write_reg(CFG_PING_PONG, with_noise($urandom_range(1), 1));
    write_reg(CFG_LOOP_ENABLE, with_noise($urandom_range(1), 1));
    case ($urandom_range(9))
      0: per = '0;
      1: per = '1;
      2: per = PERIOD_RST;
      3, 4: per = $urandom_range(1, 20);
      5, 6, 7: per = $urandom_range(1, 500);
      default: per = $urandom;
    endcase
    write_reg(CFG_FRAME_PERIOD, per);
  endtask

  initial begin
    int r;
    logic [OP_W-1:0] op;
    logic [TB_TIME_BITS-1:0] el;

    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(negedge clk_i);

    // defaults: one held frame, tick while stopped, unused codes, halt on end
    send_item(OP_TICK, '1);
    send_item(OP_RSVD_LO, '1);
    send_item(OP_START, '0);
    send_item(OP_TICK, '0);
    send_item(OP_TICK, '1);
    send_item(OP_RSVD_HI, '0);

    // backward ping-pong, zero period, zero columns, y saturates
    drain();
    write_reg(CFG_SHEET_COLUMNS, '0);
    write_reg(CFG_FRAME_WIDTH, 2047);
    write_reg(CFG_FRAME_HEIGHT, 2047);
    write_reg(CFG_FIRST_FRAME, 255);
    write_reg(CFG_LAST_FRAME, 0);
    write_reg(CFG_PING_PONG, 1);
    write_reg(CFG_LOOP_ENABLE, 1);
    write_reg(CFG_FRAME_PERIOD, '0);
    send_item(OP_START, '0);
    send_item(OP_TICK, '0);
    send_item(OP_TICK, '0);
    send_item(OP_PAUSE, '0);
    send_item(OP_TICK, 5);
    send_item(OP_RESUME, '0);
    send_item(OP_TICK, '0);
    send_item(OP_STOP, '0);

    // accumulator saturation with x past the pixel limit
    drain();
    write_reg(CFG_SHEET_COLUMNS, 256);
    write_reg(CFG_FRAME_HEIGHT, 1);
    write_reg(CFG_FIRST_FRAME, 200);
    write_reg(CFG_LAST_FRAME, 203);
    write_reg(CFG_PING_PONG, 0);
    write_reg(CFG_FRAME_PERIOD, 1);
    send_item(OP_START, '0);
    send_item(OP_TICK, '1);
    send_item(OP_TICK, '1);
    send_item(OP_TICK, '1);

    // shrink the sequence under the current position
    drain();
    write_reg(CFG_LAST_FRAME, 201);
    send_item(OP_PAUSE, '0);
    send_item(OP_RESUME, '0);
    send_item(OP_TICK, '0);

    for (int ph = 0; ph < 9; ph++) begin
      drain();
      send_idle_pct = (ph < 3) ? 27 : (ph < 6) ? 74 : 0;
      recv_stall_pct = (ph < 3) ? 74 : (ph < 6) ? 27 : 0;
      shuffle_regs();
      send_item(OP_START, $urandom);
      for (int n = 1; n < 48; n++) begin
        if (n == 24) drain();
        r = $urandom_range(99);
        if (r < 72) op = OP_TICK;
        else if (r < 79) op = OP_PAUSE;
        else if (r < 87) op = OP_RESUME;
        else if (r < 92) op = OP_START;
        else if (r < 96) op = OP_STOP;
        else op = $urandom_range(OP_RSVD_LO, OP_RSVD_HI);
        case ($urandom_range(9))
          0: el = '0;
          1: el = '1;
          2, 3: el = $urandom;
          default: el = $urandom_range(shadow.period / 2, shadow.period + shadow.period / 2);
        endcase
        send_item(op, el);
      end
    end

    drain();
    if (shadow.errors == 0 && shadow.pending() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #(5_000_000);
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
